[hw/rtl/fht_pkg.sv]
`timescale 1ns / 1ps

package fht_pkg;

	localparam int FACE_W   = 10;
	localparam int VAL_W    = 32;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int ACC_BITS = 40;
	localparam int MOD_W    = 32;

	localparam int FACES_DEF     = 1024;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic OP_ACC  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
	localparam logic [VAL_W-1:0]    OUT_MAX = {VAL_W{1'b1}};

	typedef struct packed {
		logic done;
		logic over;
	} fht_div_stat_t;

endpackage

[hw/rtl/face_harmonic_transmissibility_unit.sv]
`timescale 1ns / 1ps

// Face harmonic transmissibility unit.
// Input channel (in_valid/in_stall) carries one beat per item: op, face,
// half_trans and mobility. op accumulate adds 1/(mobility*half_trans) to the
// face accumulator and returns nothing; op read-out returns one output beat
// (out_face, transmissibility, saturated, empty_res) and clears the face.
// Items are worked one at a time: each passes face reduction, then the
// accumulator read-modify-write around the radix-2 reciprocal divider,
// one quotient bit per cycle. A zero operand or empty face skips the
// divider. The read-out beat is presented in the output register right
// after its write-back cycle. While it waits under out_stall the next item
// is still accepted; a following read-out holds in write-back until the
// register frees. After reset a clearing pass writes every accumulator
// entry with in_stall high.

module face_harmonic_transmissibility_unit
	import fht_pkg::*;
#(
	parameter int FACES     = FACES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [FACE_W-1:0] face,
	input  logic [VAL_W-1:0]  half_trans,
	input  logic [VAL_W-1:0]  mobility,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [FACE_W-1:0] out_face,
	output logic [VAL_W-1:0]  transmissibility,
	output logic              saturated,
	output logic              empty_res
);

	localparam int AW = $clog2(FACES);
	localparam int CW = $clog2(3 * FRAC_BITS + 1);
	localparam int DW = ACC_BITS + 1;
	localparam int KW = $clog2(FACE_W);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MOD  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_WB   = 3'd6;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [KW-1:0] mod_k_q;
	logic          out_valid_q;

	logic              op_q;
	logic [FACE_W-1:0] face_q;
	logic [FACE_W-1:0] red_q;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_BITS-1:0] sum_q;
	logic              flag_q;
	logic              skip_q;
	logic [FACE_W-1:0] out_face_q;
	logic [VAL_W-1:0]  out_res_q;
	logic              out_sat_q;
	logic              out_empty_q;

	logic [MOD_W-1:0] fac_sh;
	logic             mod_ge;
	logic             accept;
	logic             wb_go;
	logic             div_start;
	logic [CW-1:0]    div_exp;
	logic [PROD_W-1:0] div_divisor;
	logic [ACC_BITS-1:0] quot;
	fht_div_stat_t    div_stat;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [DW-1:0] mem_rdata;

	logic [ACC_BITS-1:0] term;
	logic [ACC_BITS:0]   sum_ext;
	logic [ACC_BITS-1:0] acc_new;
	logic                acc_sat;
	logic                res_over;
	logic [VAL_W-1:0]    res_val;
	logic                res_sat;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = state_q != S_IDLE;

	assign fac_sh = MOD_W'(FACES) << mod_k_q;
	assign mod_ge = MOD_W'(red_q) >= fac_sh;

	assign wb_go = (op_q == OP_ACC) || !out_valid_q || !out_stall;

	assign div_start   = (state_q == S_LOAD) && !(op_q == OP_ACC ? prod_q == '0
		: mem_rdata[ACC_BITS-1:0] == '0);
	assign div_exp     = (op_q == OP_ACC) ? CW'(3 * FRAC_BITS) : CW'(2 * FRAC_BITS);
	assign div_divisor = (op_q == OP_ACC) ? prod_q : PROD_W'(mem_rdata[ACC_BITS-1:0]);

	always_comb begin
		term    = (skip_q || div_stat.over) ? ACC_MAX : quot;
		sum_ext = {1'b0, sum_q} + {1'b0, term};
		acc_new = sum_ext[ACC_BITS] ? ACC_MAX : sum_ext[ACC_BITS-1:0];
		acc_sat = flag_q || skip_q || div_stat.over || sum_ext[ACC_BITS];

		res_over = div_stat.over || (quot[ACC_BITS-1:VAL_W] != '0);
		if (skip_q) begin
			res_val = OUT_MAX;
			res_sat = flag_q;
		end else if (res_over) begin
			res_val = OUT_MAX;
			res_sat = 1'b1;
		end else begin
			res_val = quot[VAL_W-1:0];
			res_sat = flag_q;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(red_q);
		mem_wdata = '0;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_WB: begin
				mem_we    = wb_go;
				mem_wdata = (op_q == OP_ACC) ? {acc_sat, acc_new} : '0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re = state_q == S_RD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			mod_k_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_WB && op_q == OP_READ && wb_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(FACES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mod_k_q <= KW'(FACE_W - 1);
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					mod_k_q <= mod_k_q - 1'b1;
					if (mod_k_q == '0) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= div_start ? S_DIV : S_WB;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wb_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			face_q <= face;
			red_q  <= face;
			prod_q <= PROD_W'(half_trans) * PROD_W'(mobility);
		end
		if (state_q == S_MOD && mod_ge) begin
			red_q <= red_q - fac_sh[FACE_W-1:0];
		end
		if (state_q == S_LOAD) begin
			sum_q  <= mem_rdata[ACC_BITS-1:0];
			flag_q <= mem_rdata[ACC_BITS];
			skip_q <= !div_start;
		end
		if (state_q == S_WB && op_q == OP_READ && wb_go) begin
			out_face_q  <= face_q;
			out_res_q   <= res_val;
			out_sat_q   <= res_sat;
			out_empty_q <= skip_q;
		end
	end

	fht_face_mem #(
		.DEPTH (FACES),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (AW'(red_q)),
		.rdata (mem_rdata)
	);

	fht_recip_div #(
		.FRAC_BITS (FRAC_BITS),
		.CW        (CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.exp_n   (div_exp),
		.divisor (div_divisor),
		.quot    (quot),
		.stat    (div_stat)
	);

	assign out_valid        = out_valid_q;
	assign out_face         = out_face_q;
	assign transmissibility = out_res_q;
	assign saturated        = out_sat_q;
	assign empty_res        = out_empty_q;

endmodule

[hw/rtl/fht_face_mem.sv]
`timescale 1ns / 1ps

module fht_face_mem
	import fht_pkg::*;
#(
	parameter int DEPTH = FACES_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = ACC_BITS + 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fht_recip_div.sv]
`timescale 1ns / 1ps

module fht_recip_div
	import fht_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int CW        = $clog2(3 * FRAC_BITS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CW-1:0]       exp_n,
	input  logic [PROD_W-1:0]   divisor,
	output logic [ACC_BITS-1:0] quot,
	output fht_div_stat_t       stat
);

	logic                busy_q;
	logic                done_q;
	logic                over_q;
	logic                first_q;
	logic [CW-1:0]       cnt_q;
	logic [PROD_W-1:0]   div_q;
	logic [PROD_W-1:0]   rem_q;
	logic [ACC_BITS-1:0] quot_q;

	logic [PROD_W:0] r2;
	logic [PROD_W:0] diff;
	logic            ge;

	assign r2   = {rem_q, first_q};
	assign diff = r2 - {1'b0, div_q};
	assign ge   = r2 >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= exp_n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q   <= divisor;
			rem_q   <= '0;
			quot_q  <= '0;
			over_q  <= 1'b0;
			first_q <= 1'b1;
		end else if (busy_q) begin
			first_q <= 1'b0;
			over_q  <= over_q | quot_q[ACC_BITS-1];
			quot_q  <= {quot_q[ACC_BITS-2:0], ge};
			rem_q   <= ge ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
		end
	end

	assign quot      = quot_q;
	assign stat.done = done_q;
	assign stat.over = over_q;

endmodule

[verif/fht_checker.sv]
`timescale 1ns / 1ps

module fht_checker
	import fht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              op,
	input  logic [FACE_W-1:0] face,
	input  logic [VAL_W-1:0]  half_trans,
	input  logic [VAL_W-1:0]  mobility,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [FACE_W-1:0] out_face,
	input  logic [VAL_W-1:0]  transmissibility,
	input  logic              saturated,
	input  logic              empty_res,
	output int                fail_count,
	output int                owed,
	output int                checked,
	output int                sat_seen,
	output int                empty_seen
);

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [VAL_W-1:0]  trans;
		logic              sat;
		logic              empty;
	} readout_t;

	logic [ACC_BITS-1:0] face_acc [FACES_DEF];
	logic                face_sticky [FACES_DEF];
	readout_t            owed_readouts [$];
	int                  errs;
	int                  n_checked;
	int                  n_sat;
	int                  n_empty;

	function automatic logic [ACC_BITS-1:0] half_face_term(input logic [VAL_W-1:0] ht,
			input logic [VAL_W-1:0] mob, output logic sat);
		logic [PROD_W-1:0] a;
		logic [PROD_W-1:0] b;
		logic [PROD_W-1:0] num;
		logic [PROD_W-1:0] quot;
		a = PROD_W'(ht);
		b = PROD_W'(mob);
		sat = 1'b0;
		if (ht == '0 || mob == '0) begin
			sat = 1'b1;
			return ACC_MAX;
		end
		num = '0;
		num[3*FRAC_BITS_DEF] = 1'b1;
		quot = num / (a * b);
		if (quot > PROD_W'(ACC_MAX)) begin
			sat = 1'b1;
			return ACC_MAX;
		end
		return quot[ACC_BITS-1:0];
	endfunction

	task automatic predict_beat(input logic o, input logic [FACE_W-1:0] f,
			input logic [VAL_W-1:0] ht, input logic [VAL_W-1:0] mob);
		int                  idx;
		logic [ACC_BITS-1:0] term;
		logic [ACC_BITS:0]   total;
		logic                sat;
		logic [PROD_W-1:0]   num;
		logic [PROD_W-1:0]   quot;
		readout_t            r;
		idx = int'(f) % FACES_DEF;
		if (o == OP_ACC) begin
			term = half_face_term(ht, mob, sat);
			total = {1'b0, face_acc[idx]} + {1'b0, term};
			if (total[ACC_BITS]) begin
				total = {1'b0, ACC_MAX};
				sat = 1'b1;
			end
			face_acc[idx] = total[ACC_BITS-1:0];
			if (sat)
				face_sticky[idx] = 1'b1;
		end else begin
			r.face = f;
			r.sat = face_sticky[idx];
			r.empty = 1'b0;
			if (face_acc[idx] == '0) begin
				r.trans = OUT_MAX;
				r.empty = 1'b1;
			end else begin
				num = '0;
				num[2*FRAC_BITS_DEF] = 1'b1;
				quot = num / PROD_W'(face_acc[idx]);
				if (quot > PROD_W'(OUT_MAX)) begin
					r.trans = OUT_MAX;
					r.sat = 1'b1;
				end else begin
					r.trans = quot[VAL_W-1:0];
				end
			end
			face_acc[idx] = '0;
			face_sticky[idx] = 1'b0;
			owed_readouts.push_back(r);
		end
	endtask

	task automatic check_readout();
		readout_t want;
		if (owed_readouts.size() == 0) begin
			errs++;
			if (errs <= 10)
				$display("%0t: unexpected readout face %0d trans %h sat %b empty %b",
					$realtime, out_face, transmissibility, saturated, empty_res);
			return;
		end
		want = owed_readouts.pop_front();
		n_checked++;
		if (want.sat)
			n_sat++;
		if (want.empty)
			n_empty++;
		if (out_face !== want.face || transmissibility !== want.trans ||
				saturated !== want.sat || empty_res !== want.empty) begin
			errs++;
			if (errs <= 10) begin
				$display("%0t: readout mismatch exp face %0d trans %h sat %b empty %b",
					$realtime, want.face, want.trans, want.sat, want.empty);
				$display("    got face %0d trans %h sat %b empty %b",
					out_face, transmissibility, saturated, empty_res);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (face_acc[i]) begin
				face_acc[i] = '0;
				face_sticky[i] = 1'b0;
			end
			owed_readouts.delete();
			errs = 0;
			n_checked = 0;
			n_sat = 0;
			n_empty = 0;
			fail_count <= 0;
			owed <= 0;
			checked <= 0;
			sat_seen <= 0;
			empty_seen <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_readout();
			if (in_valid && !in_stall)
				predict_beat(op, face, half_trans, mobility);
			fail_count <= errs;
			owed <= owed_readouts.size();
			checked <= n_checked;
			sat_seen <= n_sat;
			empty_seen <= n_empty;
		end
	end

endmodule

[verif/tb_face_harmonic_transmissibility_unit.sv]
`timescale 1ns / 1ps

module tb_face_harmonic_transmissibility_unit
	import fht_pkg::*;
();

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 150;
	localparam int TOTAL_ITEMS  = 500;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic [FACE_W-1:0] face;
	logic [VAL_W-1:0]  half_trans;
	logic [VAL_W-1:0]  mobility;
	logic              out_valid;
	logic              out_stall;
	logic [FACE_W-1:0] out_face;
	logic [VAL_W-1:0]  transmissibility;
	logic              saturated;
	logic              empty_res;

	int fail_count;
	int owed;
	int checked;
	int sat_seen;
	int empty_seen;
	int n_acc = 0;
	int n_read = 0;
	int idle_run = 0;
	bit calm = 1'b0;
	bit tx_gappy = 1'b1;
	bit rx_gappy = 1'b1;
	bit hold_req = 1'b0;

	face_harmonic_transmissibility_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.face(face),
		.half_trans(half_trans),
		.mobility(mobility),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_face(out_face),
		.transmissibility(transmissibility),
		.saturated(saturated),
		.empty_res(empty_res)
	);

	fht_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.face(face),
		.half_trans(half_trans),
		.mobility(mobility),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_face(out_face),
		.transmissibility(transmissibility),
		.saturated(saturated),
		.empty_res(empty_res),
		.fail_count(fail_count),
		.owed(owed),
		.checked(checked),
		.sat_seen(sat_seen),
		.empty_seen(empty_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// hold off the output for long stretches on request, else stall in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && rx_gappy && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
			if ($urandom_range(0, 63) == 0)
				rx_gappy = !rx_gappy;
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 31))
			0:       return '0;
			1:       return OUT_MAX;
			2, 3, 4: return $urandom;
			5:       return $urandom_range(1, 255);
			6, 7:    return 32'h0001_0000;
			default: return $urandom_range(32'h0000_1000, 32'h0080_0000);
		endcase
	endfunction

	task automatic send_beat(input logic o, input logic [FACE_W-1:0] f,
			input logic [VAL_W-1:0] h, input logic [VAL_W-1:0] m);
		if (!calm && tx_gappy && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		face <= f;
		half_trans <= h;
		mobility <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (o == OP_READ)
			n_read++;
		else
			n_acc++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
	endtask

	// mostly half-face terms followed by a read-out of the same face, some noise
	task automatic run_random(input int upto);
		logic [FACE_W-1:0] f;
		int                k;
		while (n_acc + n_read < upto) begin
			f = FACE_W'($urandom_range(0, FACES_DEF - 1));
			if ($urandom_range(0, 19) == 0)
				tx_gappy = !tx_gappy;
			if ($urandom_range(0, 4) != 0) begin
				k = $urandom_range(1, 3);
				repeat (k) send_beat(OP_ACC, f, pick_value(), pick_value());
				send_beat(OP_READ, f, $urandom, $urandom);
			end else begin
				send_beat(1'($urandom_range(0, 1)), f, pick_value(), pick_value());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_ACC;
		face <= '0;
		half_trans <= '0;
		mobility <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_beat(OP_ACC, 10'd0, 32'h0001_0000, 32'h0001_0000);
		send_beat(OP_READ, 10'd0, '0, '0);
		send_beat(OP_READ, 10'd0, OUT_MAX, OUT_MAX);
		send_beat(OP_ACC, 10'd1, '0, 32'h0001_0000);
		send_beat(OP_READ, 10'd1, '0, '0);
		send_beat(OP_ACC, 10'd2, 32'h0001_0000, '0);
		send_beat(OP_READ, 10'd2, '0, '0);
		send_beat(OP_ACC, 10'd3, 32'h0000_0001, 32'h0000_0001);
		send_beat(OP_READ, 10'd3, '0, '0);
		send_beat(OP_ACC, 10'd4, 32'h0000_0101, 32'h0000_0001);
		send_beat(OP_ACC, 10'd4, 32'h0000_0001, 32'h0000_0101);
		send_beat(OP_READ, 10'd4, '0, '0);
		send_beat(OP_READ, 10'd5, '0, '0);
		send_beat(OP_ACC, 10'd5, OUT_MAX, OUT_MAX);
		send_beat(OP_READ, 10'd5, '0, '0);
		send_beat(OP_ACC, 10'd6, 32'h0001_0000, 32'hC000_0000);
		send_beat(OP_READ, 10'd6, '0, '0);
		send_beat(OP_ACC, 10'd1023, 32'h0002_0000, 32'h0001_0000);
		send_beat(OP_ACC, 10'd1023, 32'h0001_0000, 32'h0001_0000);
		send_beat(OP_READ, 10'd1023, '0, '0);
		send_beat(OP_ACC, 10'd512, OUT_MAX, 32'h0001_0000);
		send_beat(OP_READ, 10'd512, OUT_MAX, OUT_MAX);

		run_random(180);

		// long output hold-off with read-outs queued back to back
		wait_drained();
		tx_gappy = 1'b0;
		hold_req = 1'b1;
		repeat (6)
			send_beat(OP_READ, FACE_W'($urandom_range(0, FACES_DEF - 1)),
				$urandom, $urandom);
		wait_drained();
		tx_gappy = 1'b1;

		run_random(400);
		wait_drained();

		calm = 1'b1;
		run_random(TOTAL_ITEMS);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d accumulate and %0d read-out beats, checked %0d read-outs",
			n_acc, n_read, checked);
		$display("(%0d saturated, %0d empty), with overflows and a %0d-cycle hold-off.",
			sat_seen, empty_seen, HOLD_CYCLES);
		if (fail_count == 0 && owed == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
